FILE: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescaper: beat payloads, the
// decoded job passed from front to back, and result kinds.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Job queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;
  } out_beat_t;

  // Everything one input byte causes: up to three data bytes, then an
  // optional end-of-string status.
  typedef struct packed {
    logic [1:0]      num_bytes;
    logic [2:0][7:0] bytes;
    logic            has_status;
    logic            status_err;
  } job_t;

endpackage

FILE: rtl/json_string_unescaper.sv
// ----------------------------------------------------------------------------
// json_string_unescaper
// Streaming JSON string body unescaper: one escaped byte per input beat,
// one unescaped UTF-8 byte or the end-of-string status per output beat.
// ----------------------------------------------------------------------------
//
//   channel | direction | payload     | beat
//   --------+-----------+-------------+-----------------------------------
//   in      | sink      | in_beat_t   | one raw byte, is_last on the end
//   out     | source    | out_beat_t  | data byte or final ok/error status
//
// Flow: an input beat is decoded in the cycle it is accepted; the input
//   takes one beat per cycle while the four-job queue has room. The output
//   gives one result per cycle unless out_ready stalls it, so a byte that causes
//   k results holds the serializer until all k are out; each job passes through the queue to the output register.
// Reset: synchronous; clears escape state, queue pointers and output valid.
// Stalls: out_ready low holds the output register; the queue absorbs
//   multi-result bursts and in_ready drops only when it is full.
// ----------------------------------------------------------------------------
module json_string_unescaper
  import jsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic accept;
  logic push;
  job_t job;
  logic pop;
  job_t head;
  logic empty;
  logic full;

  // Take a byte whenever the job queue has room.
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  // Front: decode escapes and build the job for this byte.
  jsu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_data (in_data),
    .push    (push),
    .job     (job)
  );

  // Decouple decode from the result stream.
  jsu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  // Back: serialize each job into output beats.
  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Escape decoder: tracks the escape state per accepted byte and turns each
// byte into a job of data bytes and an optional final status.
// ----------------------------------------------------------------------------
module jsu_front
  import jsu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_beat_t in_data,
  output logic     push,
  output job_t     job
);

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_BSLASH = 3'd1;
  localparam logic [2:0] MODE_HEX1   = 3'd2;
  localparam logic [2:0] MODE_HEX4   = 3'd5;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  logic [2:0]  mode, mode_next;
  logic [15:0] acc, acc_next;
  logic        err, err_next;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] cp;
  logic [7:0]  c;

  assign c  = in_data.in_byte;
  assign cp = {acc[11:0], hex_val};

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      hex_val = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    err_next  = err;
    job       = '0;

    if (!err) begin
      if (mode == MODE_BSLASH) begin
        mode_next     = MODE_NORMAL;
        job.num_bytes = 2'd1;
        unique case (c)
          CH_QUOTE:  job.bytes[0] = 8'h22;
          CH_BSLASH: job.bytes[0] = 8'h5c;
          CH_SLASH:  job.bytes[0] = 8'h2f;
          CH_B:      job.bytes[0] = 8'h08;
          CH_F:      job.bytes[0] = 8'h0c;
          CH_N:      job.bytes[0] = 8'h0a;
          CH_R:      job.bytes[0] = 8'h0d;
          CH_T:      job.bytes[0] = 8'h09;
          CH_U: begin
            job.num_bytes = 2'd0;
            mode_next     = MODE_HEX1;
            acc_next      = 16'd0;
          end
          default: begin
            job.num_bytes = 2'd0;
            err_next      = 1'b1;
            acc_next      = 16'd0;
          end
        endcase
      end else if (mode >= MODE_HEX1 && mode <= MODE_HEX4) begin
        if (!hex_ok) begin
          err_next  = 1'b1;
          mode_next = MODE_NORMAL;
          acc_next  = 16'd0;
        end else if (mode == MODE_HEX4) begin
          mode_next = MODE_NORMAL;
          acc_next  = 16'd0;
          if (cp <= 16'h007f) begin
            job.num_bytes = 2'd1;
            job.bytes[0]  = cp[7:0];
          end else if (cp <= 16'h07ff) begin
            job.num_bytes = 2'd2;
            job.bytes[0]  = {3'b110, cp[10:6]};
            job.bytes[1]  = {2'b10, cp[5:0]};
          end else if (cp[15:11] == 5'b11011) begin
            // surrogate range: no bytes, raise the error
            err_next = 1'b1;
          end else begin
            job.num_bytes = 2'd3;
            job.bytes[0]  = {4'b1110, cp[15:12]};
            job.bytes[1]  = {2'b10, cp[11:6]};
            job.bytes[2]  = {2'b10, cp[5:0]};
          end
        end else begin
          mode_next = mode + 3'd1;
          acc_next  = cp;
        end
      end else if (c == CH_BSLASH) begin
        mode_next = MODE_BSLASH;
      end else begin
        mode_next     = MODE_NORMAL;
        job.num_bytes = 2'd1;
        job.bytes[0]  = c;
      end
    end

    if (in_data.is_last) begin
      // an escape still open at the end is an error
      if (!err_next && mode_next != MODE_NORMAL) begin
        err_next = 1'b1;
      end
      job.has_status = 1'b1;
      job.status_err = err_next;
      mode_next      = MODE_NORMAL;
      acc_next       = 16'd0;
      err_next       = 1'b0;
    end
  end

  assign push = accept && (job.num_bytes != 2'd0 || job.has_status);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      acc  <= 16'd0;
      err  <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      acc  <= acc_next;
      err  <= err_next;
    end
  end

endmodule

FILE: rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Small job FIFO between the decoder and the result serializer.
// ----------------------------------------------------------------------------
module jsu_queue
  import jsu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  job_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Result serializer: walks the head job into the output register one result
// per cycle while out_ready allows, and pops the job as its last result is loaded.
// ----------------------------------------------------------------------------
module jsu_back
  import jsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  job_t      head,
  input  logic      empty,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic [1:0] idx;
  logic [2:0] total;
  logic       load;
  logic       is_final;
  out_beat_t  beat;

  assign total    = {1'b0, head.num_bytes} + {2'b00, head.has_status};
  assign is_final = ({1'b0, idx} + 3'd1 == total);
  assign load     = !out_valid || out_ready;
  assign pop      = load && !empty && is_final;

  always_comb begin
    beat.last = is_final;
    if ({1'b0, idx} < {1'b0, head.num_bytes}) begin
      beat.kind = KIND_DATA;
      case (idx)
        2'd0:    beat.out_byte = head.bytes[0];
        2'd1:    beat.out_byte = head.bytes[1];
        default: beat.out_byte = head.bytes[2];
      endcase
    end else begin
      beat.out_byte = 8'd0;
      beat.kind     = head.status_err ? KIND_ERR : KIND_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) begin
        idx <= is_final ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      out_data <= beat;
    end
  end

endmodule
